### src/linear_interp_resampler_assert.svh
// Assertion macros for the linear interpolation resampler checker.
// Used by lir_checker; expects clk and rst_n in the including scope.
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lir_pkg.sv
// Shared types, constants and helpers for the linear interpolation resampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package lir_pkg;

    localparam int NUM_CH           = 4;
    localparam int SAMPLE_W         = 16;
    localparam int CNT_W            = 3;
    localparam int STEP_W           = 41;
    localparam int FRAC_W           = 32;
    localparam int LIMIT_W          = 32;
    localparam int APB_DW           = 64;
    localparam int REG_IDX_W        = 2;
    localparam int APB_AW           = REG_IDX_W + 3;
    localparam int MAX_UPSAMPLE_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEP     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_S8       = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [NUM_CH-1:0] frame_t;

    typedef struct packed {
        logic [CNT_W-1:0]   channel_count;
        logic [STEP_W-1:0]  step_increment;
        logic               input_is_s8;
        logic [LIMIT_W-1:0] output_limit;
    } cfg_t;

    // channels actually used: 0 acts as 1, anything above NUM_CH as NUM_CH
    function automatic logic [CNT_W-1:0] clamp_channels(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == '0)
            r = CNT_W'(1);
        else if (n > CNT_W'(NUM_CH))
            r = CNT_W'(NUM_CH);
        return r;
    endfunction

endpackage
`default_nettype wire

### src/lir_front.sv
// Front end: takes input words and converts samples to 16-bit form.
// Depends on lir_pkg; feeds lir_fifo.
`timescale 1ns / 1ps
`default_nettype none
module lir_front (
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire lir_pkg::frame_t raw_frame,
    input  wire logic            input_is_s8,
    input  wire logic            q_full,
    output logic                 q_push,
    output lir_pkg::frame_t      q_data
);
    import lir_pkg::*;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // s8 mode: signed low byte times 256 is just the byte moved up
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (input_is_s8)
                q_data[i] = {raw_frame[i][7:0], 8'h00};
            else
                q_data[i] = raw_frame[i];
        end
    end

endmodule
`default_nettype wire

### src/lir_fifo.sv
// Short frame queue between front end and back end.
// Depends on lir_pkg; DEPTH must be 2 or more.
`timescale 1ns / 1ps
`default_nettype none
module lir_fifo #(
    parameter int DEPTH = lir_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire lir_pkg::frame_t push_data,
    input  wire logic            pop,
    output lir_pkg::frame_t      head,
    output logic                 full,
    output logic                 empty
);
    import lir_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    frame_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_QW'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_QW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

### src/lir_back.sv
// Back end: phase stepping, shared-multiplier interpolation, output register.
// Depends on lir_pkg; pops frames from lir_fifo.
`timescale 1ns / 1ps
`default_nettype none
module lir_back #(
    parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lir_pkg::cfg_t   cfg,
    input  wire lir_pkg::frame_t head,
    input  wire logic            q_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output lir_pkg::frame_t      out_frame,
    output logic                 out_last
);
    import lir_pkg::*;

    localparam int POS_W = $clog2(MAX_UPSAMPLE + 1);
    localparam logic [POS_W-1:0] POS_MAX      = POS_W'(MAX_UPSAMPLE);
    localparam logic [POS_W-1:0] POS_LASTSTEP = POS_W'(MAX_UPSAMPLE - 1);
    localparam int CH_W   = $clog2(NUM_CH);
    localparam int PROD_W = SAMPLE_W + FRAC_W + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]               state_reg, state_next;
    frame_t                   prev_reg, prev_next;
    logic                     have_prev_reg, have_prev_next;
    logic [STEP_W-1:0]        phase_reg, phase_next;
    logic [LIMIT_W-1:0]       fe_reg, fe_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [CH_W-1:0]          ch_reg, ch_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic                     last_reg, last_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    frame_t                   res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    frame_t                   out_frame_reg, out_frame_next;
    logic                     out_last_reg, out_last_next;

    logic                     ge_one;
    logic [STEP_W:0]          step_sum;
    logic [STEP_W-1:0]        phase_adv;
    logic                     emit;
    logic                     more_room;
    logic                     last_pos;
    logic                     loop_done;
    logic [CNT_W-1:0]         nch;
    logic                     ch_last;
    logic signed [SAMPLE_W:0] diff;
    logic signed [FRAC_W:0]   frac_s;
    logic signed [PROD_W-1:0] mul;
    logic signed [PROD_W-1:0] acc;
    logic signed [PROD_W-1:0] rnd;
    logic                     load_out;

    assign ge_one    = (phase_reg[STEP_W-1:FRAC_W] != '0);
    assign step_sum  = {1'b0, phase_reg} + {1'b0, cfg.step_increment};
    assign phase_adv = step_sum[STEP_W] ? {STEP_W{1'b1}} : step_sum[STEP_W-1:0];
    assign emit      = (fe_reg < cfg.output_limit);
    assign more_room = (({1'b0, fe_reg} + (LIMIT_W+1)'(1)) < {1'b0, cfg.output_limit});
    // no further output from this frame after the current one
    assign last_pos  = !((phase_adv[STEP_W-1:FRAC_W] == '0) &&
                         (pos_reg < POS_LASTSTEP) && more_room);
    assign loop_done = ge_one || (pos_reg == POS_MAX);
    assign nch       = clamp_channels(cfg.channel_count);
    assign ch_last   = ({1'b0, ch_reg} == CNT_W'(nch - CNT_W'(1)));

    assign diff   = {head[ch_reg][SAMPLE_W-1], head[ch_reg]}
                  - {prev_reg[ch_reg][SAMPLE_W-1], prev_reg[ch_reg]};
    assign frac_s = {1'b0, frac_reg};
    assign mul    = diff * frac_s;

    // prev * 2^32 + product, then truncate toward zero before dropping fraction
    assign acc = {{(PROD_W-SAMPLE_W-FRAC_W){prev_reg[ch_reg][SAMPLE_W-1]}},
                  prev_reg[ch_reg], {FRAC_W{1'b0}}} + prod_reg;
    assign rnd = acc[PROD_W-1] ? acc + PROD_W'({FRAC_W{1'b1}}) : acc;

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        phase_next     = phase_reg;
        fe_next        = fe_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        frac_next      = frac_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_frame_next = out_frame_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (!have_prev_reg)
                    begin
                        q_pop          = 1'b1;
                        prev_next      = head;
                        have_prev_next = 1'b1;
                    end
                    else if (ge_one)
                    begin
                        // skipped frame
                        q_pop      = 1'b1;
                        prev_next  = head;
                        phase_next = phase_reg - {{(STEP_W-FRAC_W-1){1'b0}}, 1'b1,
                                                  {FRAC_W{1'b0}}};
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (loop_done)
                begin
                    q_pop      = 1'b1;
                    prev_next  = head;
                    phase_next = ge_one ? phase_reg - {{(STEP_W-FRAC_W-1){1'b0}}, 1'b1,
                                                       {FRAC_W{1'b0}}}
                                        : '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    phase_next = phase_adv;
                    pos_next   = pos_reg + POS_W'(1);
                    if (emit)
                    begin
                        fe_next    = fe_reg + LIMIT_W'(1);
                        frac_next  = phase_reg[FRAC_W-1:0];
                        last_next  = last_pos;
                        ch_next    = '0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = mul;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_next[ch_reg] = rnd[FRAC_W+SAMPLE_W-1:FRAC_W];
                if (ch_last)
                    state_next = S_OUT;
                else
                begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        if (CNT_W'(i) < nch)
                            out_frame_next[i] = res_reg[i];
                        else
                            out_frame_next[i] = '0;
                    end
                    out_last_next = last_reg;
                    state_next    = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            phase_reg     <= '0;
            fe_reg        <= '0;
            pos_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            phase_reg     <= phase_next;
            fe_reg        <= fe_next;
            pos_reg       <= pos_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg      <= frac_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        res_reg       <= res_next;
        out_frame_reg <= out_frame_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_frame = out_frame_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

### src/linear_interp_resampler.sv
// Linear interpolation resampler: top level, config registers, block wiring.
// Depends on lir_pkg, lir_front, lir_fifo, lir_back.
//
// Usage:
//  - Input channel: in_valid/in_ready carry one word, an interleaved frame of
//    up to four 16-bit samples (sample_ch0..3). Words land in a short queue,
//    so in_ready stays high while the queue has room.
//  - Output channel: out_valid/out_ready carry one interpolated frame per
//    output position (out_ch0..3, unused channels zero); run_last marks the
//    last word produced by an input frame.
//  - Timing: the back end builds each output word channel by channel; the
//    channels used are served one after another by the single shared
//    multiplier (multiply, then add and round). A skipped or first frame is
//    popped without output; a frame whose positions are all held back by the
//    output limit still steps through its positions. First output follows
//    the second frame taken.
//  - Reset (rst_n low, async): registers go to 1 channel, step 1.0, s16
//    input, limit 2^32-1; the phase, emitted count and history are cleared.
//  - Receiver stall: the output register holds its word; the back end keeps
//    computing the next word and then waits, and the queue keeps taking input
//    words until it fills.
//  - Config: APB at byte address 8*i, 64-bit data; write only while idle.
`timescale 1ns / 1ps
`default_nettype none
module linear_interp_resampler #(
    parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF,
    parameter int QUEUE_DEPTH  = lir_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] sample_ch0,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] sample_ch1,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] sample_ch2,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] sample_ch3,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0]      out_ch0,
    output logic signed [lir_pkg::SAMPLE_W-1:0]      out_ch1,
    output logic signed [lir_pkg::SAMPLE_W-1:0]      out_ch2,
    output logic signed [lir_pkg::SAMPLE_W-1:0]      out_ch3,
    output logic                               run_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lir_pkg::APB_AW-1:0]    paddr,
    input  wire logic [lir_pkg::APB_DW-1:0]    pwdata,
    output logic [lir_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import lir_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    frame_t               raw_frame;
    frame_t               q_data;
    frame_t               q_head;
    frame_t               out_frame;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_CHANNELS: cfg_next.channel_count  = pwdata[CNT_W-1:0];
                REG_STEP:     cfg_next.step_increment = pwdata[STEP_W-1:0];
                REG_S8:       cfg_next.input_is_s8    = pwdata[0];
                REG_LIMIT:    cfg_next.output_limit   = pwdata[LIMIT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count  <= CNT_W'(1);
            cfg_reg.step_increment <= {{(STEP_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
            cfg_reg.input_is_s8    <= 1'b0;
            cfg_reg.output_limit   <= {LIMIT_W{1'b1}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // readback is combinational; pready is tied high
    always_comb
    begin
        case (reg_idx)
            REG_CHANNELS: prdata = APB_DW'(cfg_reg.channel_count);
            REG_STEP:     prdata = APB_DW'(cfg_reg.step_increment);
            REG_S8:       prdata = APB_DW'(cfg_reg.input_is_s8);
            REG_LIMIT:    prdata = APB_DW'(cfg_reg.output_limit);
            default:      prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign raw_frame[0] = sample_ch0;
    assign raw_frame[1] = sample_ch1;
    assign raw_frame[2] = sample_ch2;
    assign raw_frame[3] = sample_ch3;

    lir_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .raw_frame   (raw_frame),
        .input_is_s8 (cfg_reg.input_is_s8),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    lir_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    lir_back #(
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_frame (out_frame),
        .out_last  (run_last)
    );

    assign out_ch0 = out_frame[0];
    assign out_ch1 = out_frame[1];
    assign out_ch2 = out_frame[2];
    assign out_ch3 = out_frame[3];

endmodule
`default_nettype wire

### src/lir_checker.sv
// Port-level checker for the linear interpolation resampler, bound to the top.
// Depends on lir_pkg and linear_interp_resampler_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_interp_resampler_assert.svh"
module lir_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [lir_pkg::SAMPLE_W-1:0] out_ch0,
    input wire logic signed [lir_pkg::SAMPLE_W-1:0] out_ch1,
    input wire logic signed [lir_pkg::SAMPLE_W-1:0] out_ch2,
    input wire logic signed [lir_pkg::SAMPLE_W-1:0] out_ch3,
    input wire logic                               run_last,
    input wire logic                               psel,
    input wire logic                               penable,
    input wire logic                               pwrite,
    input wire logic [lir_pkg::APB_AW-1:0]         paddr,
    input wire logic [lir_pkg::APB_DW-1:0]         pwdata,
    input wire logic                               pready
);
    import lir_pkg::*;

    logic [CNT_W-1:0]   nch_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] sent_reg;
    logic [1:0]         seen_reg;
    logic               wr;
    logic [CNT_W-1:0]   nch;

    assign wr  = psel && penable && pwrite && pready;
    assign nch = clamp_channels(nch_reg);

    // shadow of what the port has written and moved
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nch_reg   <= CNT_W'(1);
            limit_reg <= {LIMIT_W{1'b1}};
            sent_reg  <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            if (wr && paddr[APB_AW-1:3] == REG_CHANNELS)
                nch_reg <= pwdata[CNT_W-1:0];
            if (wr && paddr[APB_AW-1:3] == REG_LIMIT)
                limit_reg <= pwdata[LIMIT_W-1:0];
            if (out_valid && out_ready)
                sent_reg <= sent_reg + LIMIT_W'(1);
            if (in_valid && in_ready && seen_reg != 2'd2)
                seen_reg <= seen_reg + 2'd1;
        end
    end

    `LIR_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_ch0) && $stable(out_ch1) && $stable(out_ch2) &&
        $stable(out_ch3) && $stable(run_last), "output word changed while stalled")

    `LIR_ASSERT_IMP(a_need_two_frames, out_valid, seen_reg == 2'd2,
        "output before two input frames")

    `LIR_ASSERT_IMP(a_limit, out_valid && out_ready, sent_reg < limit_reg,
        "output beyond the frame limit")

    `LIR_ASSERT_IMP(a_unused_zero, out_valid,
        (nch >= CNT_W'(2) || out_ch1 == '0) && (nch >= CNT_W'(3) || out_ch2 == '0) &&
        (nch >= CNT_W'(4) || out_ch3 == '0), "unused channel not zero")

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ch0   (out_ch0),
    .out_ch1   (out_ch1),
    .out_ch2   (out_ch2),
    .out_ch3   (out_ch3),
    .run_last  (run_last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready)
);
`default_nettype wire
